>>> hw/rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// TGA run-length encoder package
// Shared types, constants and helper functions of the scan-line encoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int unsigned PixW          = 32;
  localparam int unsigned HdrW          = 8;
  localparam int unsigned CfgW          = 3;
  localparam int unsigned RunW          = 8;
  localparam int unsigned MaxRunDefault = 128;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [CfgW-1:0] BppReset = 3'd4;
  localparam logic [HdrW-1:0] RunFlag  = 8'h80;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            end_of_line;
  } pix_in_t;

  typedef struct packed {
    logic [HdrW-1:0] packet_header;
    logic [PixW-1:0] run_pixel;
    logic            line_done;
    logic            last_result;
  } pkt_t;

  typedef struct packed {
    pkt_t pkt0;
    pkt_t pkt1;
    logic two;
  } entry_t;

  function automatic logic [PixW-1:0] pixel_mask(logic [CfgW-1:0] bpp);
    logic [PixW-1:0] m;
    case (bpp)
      3'd0, 3'd1: m = 32'h0000_00FF;
      3'd2:       m = 32'h0000_FFFF;
      3'd3:       m = 32'h00FF_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [HdrW-1:0] run_header(logic [RunW-1:0] len);
    logic [RunW-1:0] m1;
    m1 = len - RunW'(1);
    return RunFlag | {1'b0, m1[HdrW-2:0]};
  endfunction

endpackage

>>> hw/rtl/tgarle_front.sv
// ----------------------------------------------------------------------------
// TGA run-length encoder front end
// Accepts pixels, tracks the open run and builds the packets each pixel causes.
// ----------------------------------------------------------------------------
module tgarle_front import tgarle_pkg::*; #(
  parameter int unsigned MaxRun = MaxRunDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] bpp_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pix_in_t         in_data_i,
  input  logic            full_i,
  output logic            push_o,
  output entry_t          push_entry_o
);

  logic [PixW-1:0] held_q, held_d;
  logic [RunW-1:0] len_q, len_d;
  logic            open_q, open_d;

  logic [PixW-1:0] mask, pix, held_m;
  logic            accept, extend, emit_old, eol;
  pkt_t            old_pkt, eol_pkt;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign mask       = pixel_mask(bpp_i);
  assign pix        = in_data_i.pixel_value & mask;
  assign eol        = in_data_i.end_of_line;
  assign extend     = open_q && ((held_q & mask) == pix) && (len_q < RunW'(MaxRun));
  assign emit_old   = open_q && !extend;

  always_comb begin
    held_d = extend ? held_q : pix;
    len_d  = extend ? len_q + RunW'(1) : RunW'(1);
    open_d = 1'b1;
    if (eol) begin
      len_d  = '0;
      open_d = 1'b0;
    end
  end

  assign held_m = (extend ? held_q : pix) & mask;

  always_comb begin
    old_pkt.packet_header = run_header(len_q);
    old_pkt.run_pixel     = held_q & mask;
    old_pkt.line_done     = 1'b0;
    old_pkt.last_result   = !eol;

    eol_pkt.packet_header = run_header(extend ? len_q + RunW'(1) : RunW'(1));
    eol_pkt.run_pixel     = held_m;
    eol_pkt.line_done     = 1'b1;
    eol_pkt.last_result   = 1'b1;

    push_entry_o.pkt0 = emit_old ? old_pkt : eol_pkt;
    push_entry_o.pkt1 = eol_pkt;
    push_entry_o.two  = emit_old && eol;
  end

  assign push_o = accept && (emit_old || eol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      len_q  <= '0;
      open_q <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
      len_q  <= len_d;
      open_q <= open_d;
    end
  end

endmodule

>>> hw/rtl/tgarle_queue.sv
// ----------------------------------------------------------------------------
// TGA run-length encoder packet queue
// Short register queue that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
module tgarle_queue import tgarle_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tgarle_back.sv
// ----------------------------------------------------------------------------
// TGA run-length encoder output stage
// Takes queued entries and delivers their one or two packets in order.
// ----------------------------------------------------------------------------
module tgarle_back import tgarle_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t q_head_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pkt_t   out_data_o
);

  entry_t cur_q;
  logic   cur_valid_q;
  logic   sel_q;
  logic   out_fire, cur_done;

  assign out_fire    = cur_valid_q && out_ready_i;
  assign cur_done    = !cur_q.two || sel_q;
  assign pop_o       = q_valid_i && (!cur_valid_q || (out_fire && cur_done));
  assign out_valid_o = cur_valid_q;
  assign out_data_o  = sel_q ? cur_q.pkt1 : cur_q.pkt0;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      sel_q       <= 1'b0;
    end else if (out_fire) begin
      if (cur_done) begin
        cur_valid_q <= 1'b0;
        sel_q       <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/tga_rle_line_encoder.sv
// ----------------------------------------------------------------------------
// TGA run-length scan-line encoder
// Encodes a pixel stream into TGA run packets, one line at a time.
//
//   Channel   Direction  Payload                                  Handshake
//   in        input      pixel_value, end_of_line                 in_valid/in_ready
//   out       output     packet_header, run_pixel, line_done,     out_valid/out_ready
//                        last_result
//   cfg       input      bytes_per_pixel                          cfg_valid/cfg_ready
//
// One pixel is accepted per cycle while the queue is not full; a packet is held in
// the queue and then the output stage. A pixel that causes two packets occupies the
// output stage until both have left. The two-entry queue fills, and the input
// stalls, only when two-packet pixels or output stalls hold back the output stage.
// Reset closes any open run and sets bytes_per_pixel to four.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module tga_rle_line_encoder import tgarle_pkg::*; #(
  parameter int unsigned MaxRun = MaxRunDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pix_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pkt_t            out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] bpp_q;
  logic            push, full, pop, q_valid;
  entry_t          push_entry, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BppReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bpp_q <= cfg_data_i;
    end
  end

  tgarle_front #(
    .MaxRun(MaxRun)
  ) u_front (
    .clk_i,
    .rst_ni,
    .bpp_i        (bpp_q),
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  tgarle_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  tgarle_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

>>> hw/rtl/tgarle_checker.sv
// ----------------------------------------------------------------------------
// TGA run-length encoder checker
// Port-level properties of the encoder, bound to its top level.
// ----------------------------------------------------------------------------
module tgarle_checker import tgarle_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input pkt_t            out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output item dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("Stalled output item changed.");

  a_hdr_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.packet_header[HdrW-1])
    else $error("Packet header lacks the run flag.");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_done |-> out_data_o.last_result)
    else $error("Line-closing packet is not the last of its item.");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_result
      |=> out_valid_o && out_data_o.line_done)
    else $error("Second packet of an item did not follow at once.");

endmodule

bind tga_rle_line_encoder tgarle_checker u_tgarle_checker (.*);
